>>> src/assert_macros.svh
// Assertion macros shared by the RTL of the matrix multiplier.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> src/int16mm_pkg.sv
// Package for the int16 matrix multiplier: item kind codes, register indexes
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps

package int16mm_pkg;

    localparam logic [1:0] KIND_LOAD_A  = 2'd0;
    localparam logic [1:0] KIND_LOAD_B  = 2'd1;
    localparam logic [1:0] KIND_COMPUTE = 2'd2;

    localparam logic [1:0] CFG_ROWS_A = 2'd0;
    localparam logic [1:0] CFG_COLS_A = 2'd1;
    localparam logic [1:0] CFG_ROWS_B = 2'd2;
    localparam logic [1:0] CFG_COLS_B = 2'd3;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic start;
        logic issue;
        logic emit;
        logic emit_err;
    } dp_cmd_t;

    typedef struct packed {
        logic mismatch;
        logic k_last;
        logic elem_last;
        logic pipe_busy;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/int16mm_ctrl.sv
// Controller of the int16 matrix multiplier: sequences loads, the
// multiply-accumulate passes and the emission of each product word.
// Depends on int16mm_pkg.
`timescale 1ns / 1ps

module int16mm_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              kind,
    input  int16mm_pkg::dp_status_t status,
    output int16mm_pkg::dp_cmd_t    cmd
);
    import int16mm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_ERR   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load_a = (kind == KIND_LOAD_A);
                    cmd.load_b = (kind == KIND_LOAD_B);
                    if (kind == KIND_COMPUTE)
                    begin
                        if (status.mismatch)
                        begin
                            state_next = S_ERR;
                        end
                        else
                        begin
                            cmd.start  = 1'b1;
                            state_next = S_ISSUE;
                        end
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.issue = 1'b1;
                if (status.k_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // The sum is complete once the read and multiply stages are empty.
                if (!status.pipe_busy && status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.elem_last ? S_IDLE : S_ISSUE;
                end
            end
            S_ERR:
            begin
                if (status.out_free)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/int16mm_datapath.sv
// Datapath of the int16 matrix multiplier: dimension registers, the A and B
// element memories, loop counters, one multiply-accumulate unit and the
// output register. Depends on int16mm_pkg.
`timescale 1ns / 1ps

module int16mm_datapath
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [1:0]              cfg_index,
    input  logic [3:0]              cfg_data,
    input  logic [2:0]              row,
    input  logic [2:0]              col,
    input  logic signed [15:0]      value,
    input  int16mm_pkg::dp_cmd_t    cmd,
    output int16mm_pkg::dp_status_t status,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              out_row,
    output logic [2:0]              out_col,
    output logic signed [15:0]      product_sum,
    output logic                    last,
    output logic                    dim_error
);
    import int16mm_pkg::*;

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [3:0]         rows_a_reg;
    logic [3:0]         cols_a_reg;
    logic [3:0]         rows_b_reg;
    logic [3:0]         cols_b_reg;
    logic [DW-1:0]      m_dim;
    logic [DW-1:0]      n_dim;
    logic [DW-1:0]      p_dim;
    logic [DW-1:0]      q_dim;

    logic signed [15:0] store_a_reg [DEPTH];
    logic signed [15:0] store_b_reg [DEPTH];
    logic signed [15:0] a_rd_reg;
    logic signed [15:0] b_rd_reg;
    logic [AW-1:0]      wr_addr;
    logic               load_ok;
    logic [AW-1:0]      rd_addr_a;
    logic [AW-1:0]      rd_addr_b;

    logic [IW-1:0]      i_reg;
    logic [IW-1:0]      j_reg;
    logic [IW-1:0]      k_reg;
    logic [IW-1:0]      i_next;
    logic [IW-1:0]      j_next;
    logic [IW-1:0]      k_next;
    logic               i_last;
    logic               j_last;
    logic               k_last;

    logic               rd_valid_reg;
    logic               mul_valid_reg;
    logic signed [31:0] prod_full;
    logic [15:0]        prod_reg;
    logic [15:0]        acc_reg;
    logic [15:0]        acc_next;

    logic               out_valid_reg;
    logic [2:0]         out_row_reg;
    logic [2:0]         out_col_reg;
    logic [15:0]        out_sum_reg;
    logic               out_last_reg;
    logic               out_err_reg;

    function automatic logic [DW-1:0] clamp_dim(input logic [3:0] d);
        logic [DW-1:0] r;
        if (d == 4'd0)
        begin
            r = DW'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DW'(MAX_DIM);
        end
        else
        begin
            r = DW'(d);
        end
        return r;
    endfunction

    assign m_dim = clamp_dim(rows_a_reg);
    assign n_dim = clamp_dim(cols_a_reg);
    assign p_dim = clamp_dim(rows_b_reg);
    assign q_dim = clamp_dim(cols_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg <= 4'd1;
            cols_a_reg <= 4'd1;
            rows_b_reg <= 4'd1;
            cols_b_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS_A: rows_a_reg <= cfg_data;
                CFG_COLS_A: cols_a_reg <= cfg_data;
                CFG_ROWS_B: rows_b_reg <= cfg_data;
                CFG_COLS_B: cols_b_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // Element (r, c) of either matrix lives at address r * MAX_DIM + c.
    assign load_ok   = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
    assign wr_addr   = AW'(int'(row) * MAX_DIM + int'(col));
    assign rd_addr_a = AW'(int'(i_reg) * MAX_DIM + int'(k_reg));
    assign rd_addr_b = AW'(int'(k_reg) * MAX_DIM + int'(j_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && load_ok)
        begin
            store_a_reg[wr_addr] <= value;
        end
        a_rd_reg <= store_a_reg[rd_addr_a];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b && load_ok)
        begin
            store_b_reg[wr_addr] <= value;
        end
        b_rd_reg <= store_b_reg[rd_addr_b];
    end

    assign i_last = (DW'(i_reg) == m_dim - DW'(1));
    assign j_last = (DW'(j_reg) == q_dim - DW'(1));
    assign k_last = (DW'(k_reg) == n_dim - DW'(1));

    always_comb
    begin
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        acc_next = acc_reg;
        if (mul_valid_reg)
        begin
            acc_next = acc_reg + prod_reg;
        end
        if (cmd.start)
        begin
            i_next   = '0;
            j_next   = '0;
            k_next   = '0;
            acc_next = '0;
        end
        else if (cmd.issue)
        begin
            k_next = k_last ? '0 : k_reg + IW'(1);
        end
        else if (cmd.emit)
        begin
            acc_next = '0;
            if (j_last)
            begin
                j_next = '0;
                i_next = i_reg + IW'(1);
            end
            else
            begin
                j_next = j_reg + IW'(1);
            end
        end
    end

    // Only the low 16 bits of each product reach the wrapped sum.
    assign prod_full = a_rd_reg * b_rd_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_full[15:0];
        acc_reg  <= acc_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        k_reg    <= k_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.issue;
            mul_valid_reg <= rd_valid_reg;
            if (cmd.emit || cmd.emit_err)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_row_reg  <= 3'(i_reg);
            out_col_reg  <= 3'(j_reg);
            out_sum_reg  <= acc_reg;
            out_last_reg <= i_last && j_last;
            out_err_reg  <= 1'b0;
        end
        else if (cmd.emit_err)
        begin
            out_row_reg  <= 3'd0;
            out_col_reg  <= 3'd0;
            out_sum_reg  <= 16'd0;
            out_last_reg <= 1'b1;
            out_err_reg  <= 1'b1;
        end
    end

    assign status.mismatch  = (n_dim != p_dim);
    assign status.k_last    = k_last;
    assign status.elem_last = i_last && j_last;
    assign status.pipe_busy = rd_valid_reg || mul_valid_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign product_sum = out_sum_reg;
    assign last        = out_last_reg;
    assign dim_error   = out_err_reg;

endmodule

>>> src/int16_matrix_multiply.sv
// Load words are taken back to back while the block is idle. A compute word gives
// rows_a * cols_b product words; each sums cols_a reads through the single
// multiply-accumulate unit, then the two stages of read and multiply drain.
// A dimension mismatch presents its single error word once the output is free.
// Reset is asynchronous, active low; it sets the dimensions to 1 and empties
// the output register; the element memories hold undefined data until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module int16_matrix_multiply
#(
    parameter int MAX_DIM = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [15:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         out_row,
    output logic [2:0]         out_col,
    output logic signed [15:0] product_sum,
    output logic               last,
    output logic               dim_error
);
    import int16mm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    int16mm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    int16mm_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row         (row),
        .col         (col),
        .value       (value),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_row     (out_row),
        .out_col     (out_col),
        .product_sum (product_sum),
        .last        (last),
        .dim_error   (dim_error)
    );

    `ASSERT_ALWAYS(a_cmd_exclusive, $onehot0({cmd.start, cmd.issue, cmd.emit, cmd.emit_err}), "more than one datapath command at once")
    `ASSERT_IMPLY(a_emit_needs_room, cmd.emit || cmd.emit_err, status.out_free, "result written over a word still waiting")
    `ASSERT_IMPLY(a_emit_after_drain, cmd.emit, !status.pipe_busy, "product emitted before its sum is complete")
    `ASSERT_NEXT(a_err_word, cmd.emit_err, out_valid && dim_error && last, "error word not presented")

endmodule

>>> tb/int16mm_product_checker.sv
// Checker for the int16 matrix multiplier: follows register writes and accepted
// words, predicts the product words and compares them with what the block emits.
// Depends on int16mm_pkg for the item kind codes and the register indexes.
`timescale 1ns / 1ps

module int16mm_product_checker
#(
    parameter int MAX_DIM = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [3:0]         cfg_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [2:0]         row,
    input  logic [2:0]         col,
    input  logic signed [15:0] value,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [2:0]         out_row,
    input  logic [2:0]         out_col,
    input  logic signed [15:0] product_sum,
    input  logic               last,
    input  logic               dim_error,
    output int                 mismatches,
    output int                 outstanding,
    output int                 words_checked,
    output int                 dim_errors_seen
);

    import int16mm_pkg::*;

    typedef struct packed {
        logic [2:0]  r;
        logic [2:0]  c;
        logic [15:0] sum;
        logic        last;
        logic        err;
    } product_word_t;

    product_word_t pending_products[$];

    logic [15:0] a_elems [MAX_DIM*MAX_DIM];
    logic [15:0] b_elems [MAX_DIM*MAX_DIM];
    logic [3:0]  dim_rows_a;
    logic [3:0]  dim_cols_a;
    logic [3:0]  dim_rows_b;
    logic [3:0]  dim_cols_b;
    int          miss_cnt;
    int          word_cnt;
    int          err_cnt;

    function automatic int eff_dim(input logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (int'(d) > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    // Queues every word that one compute word gives, in row-major order.
    task automatic predict_product();
        int            m;
        int            n;
        int            p;
        int            q;
        logic [15:0]   acc;
        logic [31:0]   term;
        product_word_t w;
        m = eff_dim(dim_rows_a);
        n = eff_dim(dim_cols_a);
        p = eff_dim(dim_rows_b);
        q = eff_dim(dim_cols_b);
        if (n != p)
        begin
            w.r    = 3'd0;
            w.c    = 3'd0;
            w.sum  = 16'd0;
            w.last = 1'b1;
            w.err  = 1'b1;
            pending_products.push_back(w);
        end
        else
        begin
            for (int i = 0; i < m; i++)
            begin
                for (int j = 0; j < q; j++)
                begin
                    acc = 16'd0;
                    for (int k = 0; k < n; k++)
                    begin
                        term = $signed(a_elems[i*MAX_DIM + k]) *
                               $signed(b_elems[k*MAX_DIM + j]);
                        acc  = acc + term[15:0];
                    end
                    w.r    = 3'(i);
                    w.c    = 3'(j);
                    w.sum  = acc;
                    w.last = (i == m - 1) && (j == q - 1);
                    w.err  = 1'b0;
                    pending_products.push_back(w);
                end
            end
        end
    endtask

    task automatic check_word();
        product_word_t exp_w;
        word_cnt++;
        if (dim_error === 1'b1)
            err_cnt++;
        if (pending_products.size() == 0)
        begin
            miss_cnt++;
            if (miss_cnt <= 10)
                $display("%t: unexpected word row %0d col %0d sum %0d last %b err %b",
                         $realtime, out_row, out_col, product_sum, last, dim_error);
        end
        else
        begin
            exp_w = pending_products.pop_front();
            if (out_row !== exp_w.r || out_col !== exp_w.c || product_sum !== exp_w.sum ||
                last !== exp_w.last || dim_error !== exp_w.err)
            begin
                miss_cnt++;
                if (miss_cnt <= 10)
                    $display("%t: mismatch: expected row %0d col %0d sum %0d last %b err %b, got row %0d col %0d sum %0d last %b err %b",
                             $realtime, exp_w.r, exp_w.c, $signed(exp_w.sum), exp_w.last,
                             exp_w.err, out_row, out_col, product_sum, last, dim_error);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_products.delete();
            dim_rows_a      = 4'd1;
            dim_cols_a      = 4'd1;
            dim_rows_b      = 4'd1;
            dim_cols_b      = 4'd1;
            miss_cnt        = 0;
            word_cnt        = 0;
            err_cnt         = 0;
            mismatches      <= 0;
            outstanding     <= 0;
            words_checked   <= 0;
            dim_errors_seen <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROWS_A: dim_rows_a = cfg_data;
                    CFG_COLS_A: dim_cols_a = cfg_data;
                    CFG_ROWS_B: dim_rows_b = cfg_data;
                    CFG_COLS_B: dim_cols_b = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                case (kind)
                    KIND_LOAD_A:  a_elems[int'(row)*MAX_DIM + int'(col)] = value;
                    KIND_LOAD_B:  b_elems[int'(row)*MAX_DIM + int'(col)] = value;
                    KIND_COMPUTE: predict_product();
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                check_word();
            mismatches      <= miss_cnt;
            outstanding     <= pending_products.size();
            words_checked   <= word_cnt;
            dim_errors_seen <= err_cnt;
        end
    end

endmodule

>>> tb/int16_matrix_multiply_tb.sv
// Testbench top for the int16 matrix multiplier: clock, reset, register writes,
// load and compute words with random gaps and output stalls, and the verdict.
// Depends on int16mm_pkg, the block itself and int16mm_product_checker.
`timescale 1ns / 1ps

module int16_matrix_multiply_tb;

    import int16mm_pkg::*;

    localparam int         MAX_DIM      = 8;
    localparam logic [1:0] KIND_UNUSED  = 2'd3;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         ITEM_TARGET  = 450;

    typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_BURSTY} stall_mode_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [3:0]         cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         kind;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [2:0]         out_row;
    logic [2:0]         out_col;
    logic signed [15:0] product_sum;
    logic               last;
    logic               dim_error;

    int mismatches;
    int outstanding;
    int words_checked;
    int dim_errors_seen;

    // Stimulus bookkeeping: which store entries hold data, and the live sizes.
    bit         a_set [MAX_DIM*MAX_DIM];
    bit         b_set [MAX_DIM*MAX_DIM];
    logic [3:0] cur_ra;
    logic [3:0] cur_ca;
    logic [3:0] cur_rb;
    logic [3:0] cur_cb;
    int         items_sent;
    int         computes;
    int         burst_left;
    bit         steady;
    bit         hold_done;

    event        hold_evt;
    logic        holding;
    stall_mode_t stall_mode;
    int          mode_left;
    int          stall_burst;
    bit          stall_level;
    int          cycle_no;

    int16_matrix_multiply #(.MAX_DIM(MAX_DIM)) u_top (.*);

    int16mm_product_checker #(.MAX_DIM(MAX_DIM)) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .row             (row),
        .col             (col),
        .value           (value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_row         (out_row),
        .out_col         (out_col),
        .product_sum     (product_sum),
        .last            (last),
        .dim_error       (dim_error),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .words_checked   (words_checked),
        .dim_errors_seen (dim_errors_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #50_000_000;
        $display("Timeout with %0d words still expected", outstanding);
        $display("FAILED: results differ");
        $finish;
    end

    // Long receiver hold-off, started by the stimulus and counted here.
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_evt);
            holding <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding <= 1'b0;
        end
    end

    initial
    begin
        stall_mode  = STALL_NONE;
        mode_left   = 0;
        stall_burst = 0;
        stall_level = 1'b0;
        cycle_no    = 0;
    end

    always @(posedge clk)
    begin
        cycle_no++;
        if (mode_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            mode_left  = $urandom_range(20, 200);
        end
        else
            mode_left--;
        case (stall_mode)
            STALL_NONE:     stall_level = 1'b0;
            STALL_RANDOM:   stall_level = ($urandom_range(0, 2) == 0);
            STALL_PERIODIC: stall_level = (cycle_no % 3 == 0);
            default:
            begin
                if (stall_burst == 0)
                begin
                    stall_burst = $urandom_range(1, 8);
                    stall_level = ~stall_level;
                end
                else
                    stall_burst--;
            end
        endcase
        out_stall <= stall_level || holding;
    end

    function automatic int eff_dim(input logic [3:0] d);
        if (d == 4'd0)
            return 1;
        if (int'(d) > MAX_DIM)
            return MAX_DIM;
        return int'(d);
    endfunction

    function automatic logic [3:0] pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 4'd0;
        if (r == 1)
            return 4'($urandom_range(9, 15));
        if (r <= 3)
            return 4'd8;
        return 4'($urandom_range(1, 4));
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offers one word and returns after the edge that accepts it, or after a random gap when not steady.
    task automatic send_word(input logic [1:0] k, input logic [2:0] r, input logic [2:0] c,
                             input logic [15:0] v);
        int gap;
        in_valid <= 1'b1;
        kind     <= k;
        row      <= r;
        col      <= c;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        if (k != KIND_UNUSED)
            items_sent++;
        if (k == KIND_LOAD_A)
            a_set[int'(r)*MAX_DIM + int'(c)] = 1'b1;
        if (k == KIND_LOAD_B)
            b_set[int'(r)*MAX_DIM + int'(c)] = 1'b1;
        if (!steady)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(1, 4);
                // The payload is junk while valid is low.
                in_valid <= 1'b0;
                kind     <= 2'($urandom);
                row      <= 3'($urandom);
                col      <= 3'($urandom);
                value    <= 16'($urandom);
                repeat (gap) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    task automatic set_dims(input logic [3:0] ra, input logic [3:0] ca,
                            input logic [3:0] rb, input logic [3:0] cb);
        wait_idle();
        write_reg(CFG_ROWS_A, ra);
        write_reg(CFG_COLS_A, ca);
        write_reg(CFG_ROWS_B, rb);
        write_reg(CFG_COLS_B, cb);
        cfg_we <= 1'b0;
        cur_ra = ra;
        cur_ca = ca;
        cur_rb = rb;
        cur_cb = cb;
    endtask

    // When the inner sizes agree, loads whatever operand the product needs and has not
    // been written; then issues the compute word with random filler in its unused fields.
    task automatic compute_product();
        int m;
        int n;
        int q;
        m = eff_dim(cur_ra);
        n = eff_dim(cur_ca);
        q = eff_dim(cur_cb);
        if (n == eff_dim(cur_rb))
        begin
            for (int i = 0; i < m; i++)
                for (int k = 0; k < n; k++)
                    if (!a_set[i*MAX_DIM + k])
                        send_word(KIND_LOAD_A, 3'(i), 3'(k), rand_value());
            for (int k = 0; k < n; k++)
                for (int j = 0; j < q; j++)
                    if (!b_set[k*MAX_DIM + j])
                        send_word(KIND_LOAD_B, 3'(k), 3'(j), rand_value());
        end
        send_word(KIND_COMPUTE, 3'($urandom), 3'($urandom), 16'($urandom));
        computes++;
    endtask

    task automatic touch_region(input int count);
        int m;
        int n;
        int p;
        int q;
        m = eff_dim(cur_ra);
        n = eff_dim(cur_ca);
        p = eff_dim(cur_rb);
        q = eff_dim(cur_cb);
        repeat (count)
        begin
            if ($urandom_range(0, 1) == 0)
                send_word(KIND_LOAD_A, 3'($urandom_range(0, m - 1)),
                          3'($urandom_range(0, n - 1)), rand_value());
            else
                send_word(KIND_LOAD_B, 3'($urandom_range(0, p - 1)),
                          3'($urandom_range(0, q - 1)), rand_value());
        end
    endtask

    initial
    begin
        int          waited;
        int          pick;
        logic [3:0]  nxt_ra;
        logic [3:0]  nxt_ca;
        logic [3:0]  nxt_rb;
        logic [3:0]  nxt_cb;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = CFG_ROWS_A;
        cfg_data   = 4'd0;
        in_valid   = 1'b0;
        kind       = KIND_LOAD_A;
        row        = 3'd0;
        col        = 3'd0;
        value      = 16'sd0;
        out_stall  = 1'b0;
        cur_ra     = 4'd1;
        cur_ca     = 4'd1;
        cur_rb     = 4'd1;
        cur_cb     = 4'd1;
        items_sent = 0;
        computes   = 0;
        burst_left = 0;
        steady     = 1'b1;
        hold_done  = 1'b0;
        foreach (a_set[i])
        begin
            a_set[i] = 1'b0;
            b_set[i] = 1'b0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Products at the corners of the int16 range, all sizes at their reset of one.
        send_word(KIND_LOAD_A, 3'd0, 3'd0, 16'h7FFF);
        send_word(KIND_LOAD_B, 3'd0, 3'd0, 16'h7FFF);
        compute_product();
        send_word(KIND_LOAD_A, 3'd0, 3'd0, 16'h8000);
        compute_product();
        send_word(KIND_LOAD_B, 3'd0, 3'd0, 16'h8000);
        compute_product();
        send_word(KIND_UNUSED, 3'd7, 3'd7, 16'hFFFF);
        // A size of zero counts as one.
        set_dims(4'd0, 4'd0, 4'd0, 4'd0);
        compute_product();
        // Oversized sizes count as eight: an outer product of a column and a row.
        set_dims(4'd15, 4'd0, 4'd1, 4'd15);
        compute_product();
        // Inner sizes that disagree give a single error word.
        set_dims(4'd2, 4'd3, 4'd2, 4'd2);
        compute_product();

        steady = 1'b0;
        while (items_sent < ITEM_TARGET)
        begin
            steady = ($urandom_range(0, 4) == 0);
            if (!hold_done && items_sent >= 220)
            begin
                // Output held off while computes keep coming, so the block backs up.
                hold_done = 1'b1;
                set_dims(4'd3, 4'd3, 4'd3, 4'd3);
                compute_product();
                steady = 1'b1;
                -> hold_evt;
                repeat (6)
                begin
                    touch_region(1);
                    compute_product();
                end
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    if ($urandom_range(0, 1) == 0)
                    begin
                        nxt_ra = pick_dim();
                        nxt_ca = pick_dim();
                        nxt_cb = pick_dim();
                        nxt_rb = nxt_ca;
                        if ($urandom_range(0, 2) == 0)
                        begin
                            if (eff_dim(nxt_ca) == MAX_DIM)
                                nxt_rb = 4'($urandom_range(MAX_DIM, 15));
                            else if (eff_dim(nxt_ca) == 1)
                                nxt_rb = 4'($urandom_range(0, 1));
                        end
                        set_dims(nxt_ra, nxt_ca, nxt_rb, nxt_cb);
                    end
                    if (eff_dim(cur_ca) == eff_dim(cur_rb))
                        touch_region($urandom_range(0, 6));
                    compute_product();
                    if ($urandom_range(0, 3) == 0)
                        compute_product();
                end
                else if (pick < 9)
                begin
                    repeat ($urandom_range(1, 5))
                    begin
                        case ($urandom_range(0, 2))
                            0: send_word(KIND_LOAD_A, 3'($urandom), 3'($urandom), rand_value());
                            1: send_word(KIND_LOAD_B, 3'($urandom), 3'($urandom), rand_value());
                            default: send_word(KIND_UNUSED, 3'($urandom), 3'($urandom),
                                               16'($urandom));
                        endcase
                    end
                end
                else
                begin
                    nxt_ca = pick_dim();
                    nxt_rb = 4'((eff_dim(nxt_ca) % MAX_DIM) + 1);
                    set_dims(pick_dim(), nxt_ca, nxt_rb, pick_dim());
                    compute_product();
                end
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        for (waited = 0; outstanding != 0 && waited < 50000; waited++)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d load and compute words, %0d of them computes, with gaps and stalls.",
                 items_sent, computes);
        $display("Checked %0d output words, %0d of them dimension errors.",
                 words_checked, dim_errors_seen);
        if (outstanding != 0)
            $display("%0d expected words never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
